### rtl/cptc_pkg.sv
// shared types and constants for the cascaded pi traction controller
`timescale 1ns / 1ps
package cptc_pkg;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_VEL_P = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_I = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SLIP_P = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLIP_I = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_P = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACC_I = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_VSCALE = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ASCALE = 3'd7;

  // datapath step codes
  typedef enum logic [3:0] {
    OP_NONE, OP_LOAD, OP_MVEL, OP_FVEL, OP_ACC, OP_VINT, OP_VERR,
    OP_SINT, OP_CORR, OP_AINT, OP_CMD, OP_HOLD
  } op_t;

  typedef struct packed {
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic enable;
    logic use_slip;
  } status_t;

endpackage

### rtl/cptc_datapath.sv
// datapath: operand registers, one shared multiplier stage, clamps and state
`timescale 1ns / 1ps
module cptc_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [cptc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [cptc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [31:0]                     in_drive_count,
  input  logic [31:0]                     in_follow_count,
  input  logic signed [17:0]              in_speed_command,
  input  logic [16:0]                     in_elapsed_time,
  input  logic signed [17:0]              in_present_drive,
  input  logic                            in_enable,
  input  logic                            in_use_slip,
  input  cptc_pkg::cmd_t                  cmd,
  output cptc_pkg::status_t               status,
  output logic signed [17:0]              motor_command,
  output logic                            command_valid
);
  import cptc_pkg::*;

  logic [15:0] vel_p_gain, vel_i_gain, slip_p_gain, slip_i_gain;
  logic [15:0] accel_p_gain, accel_i_gain, accel_scale;
  logic [23:0] velocity_scale;

  logic [31:0] last_drive_count, last_follow_count;
  logic signed [17:0] last_motor_velocity;
  logic signed [17:0] velocity_integral, slip_integral, accel_integral;

  logic [31:0] drive_count, follow_count;
  logic signed [17:0] speed_command, present_drive;
  logic [16:0] elapsed_time;
  logic enable, use_slip;

  logic signed [17:0] mv, rv, acc, verr;
  logic signed [19:0] vd, slip;
  // correction and accel error run well past the q2.16 range
  logic signed [23:0] corr, aerr;

  // one multiplier: signed a (33b) times unsigned b (25b)
  logic signed [32:0] mul_a;
  logic signed [24:0] mul_b;
  logic signed [57:0] prod;

  function automatic logic signed [17:0] sat18(input logic signed [59:0] v);
    if (v > 60'sd131071) return 18'sd131071;
    if (v < -60'sd131072) return -18'sd131072;
    return v[17:0];
  endfunction

  function automatic logic signed [59:0] clampv(input logic signed [59:0] v,
                                                input logic signed [59:0] lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      OP_MVEL: begin
        mul_a = 33'(signed'(drive_count - last_drive_count));
        mul_b = {1'b0, velocity_scale};
      end
      OP_FVEL: begin
        mul_a = 33'(signed'(follow_count - last_follow_count));
        mul_b = {1'b0, velocity_scale};
      end
      OP_ACC: begin
        mul_a = 33'(mv) - 33'(last_motor_velocity);
        mul_b = {9'd0, accel_scale};
      end
      OP_VINT: begin mul_a = 33'(vd); mul_b = {9'd0, vel_i_gain}; end
      OP_VERR: begin mul_a = 33'(vd); mul_b = {9'd0, vel_p_gain}; end
      OP_SINT: begin mul_a = 33'(slip); mul_b = {9'd0, slip_i_gain}; end
      OP_CORR: begin mul_a = 33'(slip); mul_b = {9'd0, slip_p_gain}; end
      OP_AINT: begin mul_a = 33'(aerr); mul_b = {9'd0, accel_i_gain}; end
      OP_CMD:  begin mul_a = 33'(aerr); mul_b = {9'd0, accel_p_gain}; end
      default: ;
    endcase
    prod = mul_a * mul_b;
  end

  logic signed [59:0] p8, p4, p12;
  logic signed [59:0] t_cmd, lo, hi;
  logic signed [19:0] sd;
  always_comb begin
    p8 = 60'(prod >>> 8);
    p4 = 60'(prod >>> 4);
    p12 = 60'(prod >>> 12);
    sd = 20'(mv) - 20'(rv);
    lo = 60'(present_drive) - 60'(signed'({1'b0, elapsed_time}));
    hi = 60'(present_drive) + 60'(signed'({1'b0, elapsed_time}));
    t_cmd = p12 + 60'(accel_integral);
    if (!use_slip) begin
      if (t_cmd < lo) t_cmd = lo;
      else if (t_cmd > hi) t_cmd = hi;
    end
  end

  assign status.enable = enable;
  assign status.use_slip = use_slip;

  always_ff @(posedge clk) begin
    if (rst) begin
      vel_p_gain <= '0; vel_i_gain <= '0; slip_p_gain <= '0; slip_i_gain <= '0;
      accel_p_gain <= 16'd4096; accel_i_gain <= '0;
      velocity_scale <= '0; accel_scale <= '0;
      last_drive_count <= '0; last_follow_count <= '0; last_motor_velocity <= '0;
      velocity_integral <= '0; slip_integral <= '0; accel_integral <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_VEL_P: vel_p_gain <= cfg_data[15:0];
          REG_VEL_I: vel_i_gain <= cfg_data[15:0];
          REG_SLIP_P: slip_p_gain <= cfg_data[15:0];
          REG_SLIP_I: slip_i_gain <= cfg_data[15:0];
          REG_ACC_P: accel_p_gain <= cfg_data[15:0];
          REG_ACC_I: accel_i_gain <= cfg_data[15:0];
          REG_VSCALE: velocity_scale <= cfg_data;
          REG_ASCALE: accel_scale <= cfg_data[15:0];
          default: ;
        endcase
      end
      unique case (cmd.op)
        OP_FVEL: begin
          if (!enable) begin
            velocity_integral <= '0; slip_integral <= '0; accel_integral <= '0;
          end else if (!use_slip) begin
            slip_integral <= '0;
          end
        end
        OP_VINT: velocity_integral <= 18'(clampv(p12 + 60'(velocity_integral),
                                                 60'sd65536));
        OP_SINT: slip_integral <= 18'(clampv(p12 + 60'(slip_integral),
                                             60'sd58982));
        OP_AINT: accel_integral <= 18'(clampv(p12 + 60'(accel_integral),
                                              60'sd65536));
        OP_CMD, OP_HOLD: begin
          last_drive_count <= drive_count;
          last_follow_count <= follow_count;
          last_motor_velocity <= mv;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        drive_count <= in_drive_count; follow_count <= in_follow_count;
        speed_command <= in_speed_command; elapsed_time <= in_elapsed_time;
        present_drive <= in_present_drive; enable <= in_enable;
        use_slip <= in_use_slip;
      end
      OP_MVEL: mv <= sat18(p8);
      OP_FVEL: rv <= sat18(p8);
      OP_ACC: begin
        acc <= (accel_scale == '0) ? '0 : sat18(p4);
        vd <= 20'(speed_command) - 20'(mv);
        if (!use_slip || (sd <= 20'sd655 && sd >= -20'sd655)) slip <= '0;
        else slip <= sd;
      end
      OP_VERR: verr <= 18'(clampv(p12 + 60'(velocity_integral), 60'sd65536));
      OP_CORR: corr <= 24'(p12 + 60'(slip_integral));
      OP_AINT: ;
      OP_SINT: ;
      OP_VINT: ;
      OP_CMD: begin
        motor_command <= sat18(t_cmd);
        command_valid <= 1'b1;
      end
      OP_HOLD: begin
        motor_command <= present_drive;
        command_valid <= 1'b0;
      end
      default: ;
    endcase
  end

  // aerr formed after the correction register settles
  always_comb begin
    aerr = 24'(60'(verr) - 60'(corr) - 60'(acc));
  end

endmodule

### rtl/cptc_ctrl.sv
// controller: sequences one tick through the shared multiplier
`timescale 1ns / 1ps
module cptc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  cptc_pkg::status_t status,
  output cptc_pkg::cmd_t    cmd
);
  import cptc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MVEL, S_FVEL, S_ACC, S_VINT, S_VERR, S_SINT, S_CORR,
    S_AINT, S_CMD, S_WAIT
  } state_t;
  state_t state;

  assign in_ready = (state == S_IDLE) || (state == S_WAIT && out_ready);

  always_comb begin
    cmd.op = OP_NONE;
    unique case (state)
      S_IDLE: if (in_valid) cmd.op = OP_LOAD;
      S_WAIT: if (out_ready && in_valid) cmd.op = OP_LOAD;
      S_MVEL: cmd.op = OP_MVEL;
      S_FVEL: cmd.op = OP_FVEL;
      S_ACC:  cmd.op = OP_ACC;
      S_VINT: cmd.op = OP_VINT;
      S_VERR: cmd.op = OP_VERR;
      S_SINT: cmd.op = OP_SINT;
      S_CORR: cmd.op = OP_CORR;
      S_AINT: cmd.op = OP_AINT;
      S_CMD:  cmd.op = status.enable ? OP_CMD : OP_HOLD;
      default: cmd.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: if (in_valid) state <= S_MVEL;
        S_MVEL: state <= S_FVEL;
        S_FVEL: state <= status.enable ? S_ACC : S_CMD;
        S_ACC:  state <= S_VINT;
        S_VINT: state <= S_VERR;
        S_VERR: state <= S_SINT;
        S_SINT: state <= S_CORR;
        S_CORR: state <= S_AINT;
        S_AINT: state <= S_CMD;
        S_CMD: begin
          state <= S_WAIT;
          out_valid <= 1'b1;
        end
        S_WAIT: if (out_ready) begin
          out_valid <= 1'b0;
          state <= in_valid ? S_MVEL : S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_valid_wait: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> state == S_WAIT) else $error("out_valid outside wait");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_no_load: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE && state != S_WAIT) |-> !in_ready) else $error("load mid tick");

endmodule

### rtl/cascaded_pi_traction_control_core.sv
// top level of the cascaded pi traction controller
`timescale 1ns / 1ps
// an enabled item walks the single shared multiplier through nine steps
// of the loop cascade before its result appears on m_axis; a new item is
// taken only once the last result is taken, and it loads in the cycle its
// predecessor's result is taken
// a disabled tick skips the loop steps
// reset (rst, synchronous): state and integrators zero, gains to reset values
module cascaded_pi_traction_control_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // drive_count[31:0], follow_count[63:32], speed_command[81:64],
  // elapsed_time[98:82], present_drive[116:99], zero fill
  input  logic [119:0] s_axis_tdata,
  // enable[0], use_slip[1]
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // motor_command[17:0], zero fill
  output logic [23:0] m_axis_tdata,
  // command_valid
  output logic        m_axis_tuser
);
  import cptc_pkg::*;

  cmd_t cmd;
  status_t status;
  logic signed [17:0] motor_command;

  cptc_ctrl u_ctrl (
    .clk, .rst,
    .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
    .status, .cmd
  );

  cptc_datapath u_dp (
    .clk, .rst,
    .cfg_we, .cfg_idx(cfg_index), .cfg_data,
    .in_drive_count(s_axis_tdata[31:0]),
    .in_follow_count(s_axis_tdata[63:32]),
    .in_speed_command(s_axis_tdata[81:64]),
    .in_elapsed_time(s_axis_tdata[98:82]),
    .in_present_drive(s_axis_tdata[116:99]),
    .in_enable(s_axis_tuser[0]),
    .in_use_slip(s_axis_tuser[1]),
    .cmd, .status,
    .motor_command,
    .command_valid(m_axis_tuser)
  );

  // result field padded to whole bytes
  assign m_axis_tdata = {6'd0, motor_command};

endmodule

### tb/tb_cptc_checker.sv
// checker for the cascaded pi traction controller: predicts and compares results
`timescale 1ns / 1ps
module tb_cptc_checker (
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [23:0]  cfg_data,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [119:0] s_axis_tdata,
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [23:0]  m_axis_tdata,
  input  logic         m_axis_tuser,
  output int           fail_count,
  output int           pending
);
  import cptc_pkg::*;

  typedef struct packed {
    logic [17:0] motor_command;
    logic        command_valid;
  } drive_result_t;

  drive_result_t expected_cmds[$];

  logic [15:0] g_vp, g_vi, g_sp, g_si, g_ap, g_ai, g_as;
  logic [23:0] g_vs;
  logic [31:0] prev_drive, prev_follow;
  longint prev_mvel, int_vel, int_slip, int_acc;

  function automatic longint clip(longint v, longint lo, longint hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // >>> on signed longint is arithmetic, i.e. floor
  function automatic longint gmul(longint v, logic [15:0] g);
    return (v * longint'(g)) >>> 12;
  endfunction

  function automatic longint speed_of(logic [31:0] now, logic [31:0] last);
    logic [31:0] d;
    d = now - last;
    return clip((longint'($signed(d)) * longint'(g_vs)) >>> 8, -131072, 131071);
  endfunction

  task automatic predict_tick(input logic [119:0] d, input logic [1:0] u);
    longint mv, fv, cmd_spd, t, pres, res, acc, vd, verr, slp, corr, aerr, cmd;
    drive_result_t r;
    mv = speed_of(d[31:0], prev_drive);
    fv = speed_of(d[63:32], prev_follow);
    cmd_spd = longint'($signed(d[81:64]));
    t = longint'(d[98:82]);
    pres = longint'($signed(d[116:99]));
    res = pres;
    if (!u[0]) begin
      int_vel = 0; int_slip = 0; int_acc = 0;
    end else begin
      if (!u[1]) int_slip = 0;
      acc = clip(((mv - prev_mvel) * longint'(g_as)) >>> 4, -131072, 131071);
      vd = cmd_spd - mv;
      int_vel = clip(int_vel + gmul(vd, g_vi), -65536, 65536);
      verr = clip(gmul(vd, g_vp) + int_vel, -65536, 65536);
      slp = u[1] ? (mv - fv) : 0;
      // dead band around zero slip
      if (slp <= 655 && slp >= -655) slp = 0;
      int_slip = clip(int_slip + gmul(slp, g_si), -58982, 58982);
      corr = gmul(slp, g_sp) + int_slip;
      aerr = verr - corr - acc;
      int_acc = clip(int_acc + gmul(aerr, g_ai), -65536, 65536);
      cmd = gmul(aerr, g_ap) + int_acc;
      if (!u[1]) cmd = clip(cmd, pres - t, pres + t);
      res = clip(cmd, -131072, 131071);
    end
    prev_drive = d[31:0];
    prev_follow = d[63:32];
    prev_mvel = mv;
    r.motor_command = res[17:0];
    r.command_valid = u[0];
    expected_cmds.push_back(r);
  endtask

  task automatic report_mismatch(input string what, input longint got, input longint exp);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
    fail_count++;
  endtask

  assign pending = expected_cmds.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    drive_result_t e;
    if (rst) begin
      g_vp <= 0; g_vi <= 0; g_sp <= 0; g_si <= 0;
      g_ap <= 16'd4096; g_ai <= 0; g_vs <= 0; g_as <= 0;
      prev_drive = 0; prev_follow = 0; prev_mvel = 0;
      int_vel = 0; int_slip = 0; int_acc = 0;
      expected_cmds.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_VEL_P:  g_vp <= cfg_data[15:0];
          REG_VEL_I:  g_vi <= cfg_data[15:0];
          REG_SLIP_P: g_sp <= cfg_data[15:0];
          REG_SLIP_I: g_si <= cfg_data[15:0];
          REG_ACC_P:  g_ap <= cfg_data[15:0];
          REG_ACC_I:  g_ai <= cfg_data[15:0];
          REG_VSCALE: g_vs <= cfg_data;
          REG_ASCALE: g_as <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) predict_tick(s_axis_tdata, s_axis_tuser);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_cmds.size() == 0) begin
          report_mismatch("unexpected result", $signed(m_axis_tdata[17:0]), 0);
        end else begin
          e = expected_cmds.pop_front();
          if (m_axis_tdata[17:0] !== e.motor_command)
            report_mismatch("motor_command", $signed(m_axis_tdata[17:0]),
                            $signed(e.motor_command));
          if (m_axis_tdata[23:18] !== 6'd0)
            report_mismatch("tdata fill", m_axis_tdata[23:18], 0);
          if (m_axis_tuser !== e.command_valid)
            report_mismatch("command_valid", m_axis_tuser, e.command_valid);
        end
      end
    end
  end
endmodule

### tb/tb_cascaded_pi_traction_control_core.sv
// testbench top for the cascaded pi traction controller: stimulus and verdict
`timescale 1ns / 1ps
module tb_cascaded_pi_traction_control_core;
  import cptc_pkg::*;

  logic         clk, rst;
  logic         cfg_we;
  logic [2:0]   cfg_index;
  logic [23:0]  cfg_data;
  logic         s_axis_tvalid, s_axis_tready;
  // drive_count, follow_count, speed_command, elapsed_time, present_drive, zero fill
  logic [119:0] s_axis_tdata;
  // enable, use_slip
  logic [1:0]   s_axis_tuser;
  logic         m_axis_tvalid, m_axis_tready;
  // motor_command, zero fill
  logic [23:0]  m_axis_tdata;
  // command_valid
  logic         m_axis_tuser;
  int           fail_count, pending;
  int           cycle_count;
  bit           hold_sink;      // long receiver hold-off requested
  bit           sink_burst;     // stretch of receiver with no stalls

  // walking counts so that deltas stay in a useful range most of the time
  logic [31:0]  drive_pos, follow_pos;

  cascaded_pi_traction_control_core dut (.*);

  tb_cptc_checker chk (.*);

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  // run limit: item processing plus gaps and stalls, taken many times over
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count > 400000) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: random stalls, a stall-free stretch, and a long hold-off on request
  initial begin
    int n;
    m_axis_tready = 0;
    sink_burst = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_sink) begin
        m_axis_tready <= 0;
        repeat (300) @(negedge clk);
        hold_sink = 0;
      end
      if (sink_burst) begin
        m_axis_tready <= 1;
        @(negedge clk);
      end else begin
        n = gap_len();
        if (n > 0) begin
          m_axis_tready <= 0;
          repeat (n) @(negedge clk);
        end
        m_axis_tready <= 1;
        @(negedge clk);
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [23:0] val);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    @(negedge clk);
  endtask

  // drop the last offered item, wait until every result has come,
  // then past the block's latency
  task automatic drain();
    s_axis_tvalid <= 0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  // leaves tvalid high after the accept; the next send or drain lowers it
  task automatic send_tick(input logic [31:0] dc, input logic [31:0] fc,
                           input logic [17:0] spd, input logic [16:0] et,
                           input logic [17:0] pres, input logic en, input logic slp,
                           input bit no_gap);
    int n;
    if (!no_gap) begin
      n = gap_len();
      if (n > 0) begin
        s_axis_tvalid <= 0;
        repeat (n) @(negedge clk);
      end
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= {3'b000, pres, et, spd, fc, dc};
    s_axis_tuser <= {slp, en};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [17:0] rand_q();
    case ($urandom_range(0, 5))
      0: return 18'sd65536;
      1: return -18'sd65536;
      2: return 18'($urandom());
      default: return 18'($urandom_range(0, 131072) - 65536);
    endcase
  endfunction

  task automatic rand_tick(input bit no_gap);
    int r;
    logic [31:0] ddelta, fdelta;
    r = $urandom_range(0, 9);
    // mostly small steps, some huge ones and wraparound
    ddelta = (r < 7) ? $urandom_range(0, 2000) - 1000 : $urandom();
    fdelta = ($urandom_range(0, 3) == 0) ? ddelta + $urandom_range(0, 20) - 10
                                         : ddelta + $urandom_range(0, 600) - 300;
    if (r == 9) fdelta = $urandom();
    drive_pos += ddelta;
    follow_pos += fdelta;
    send_tick(drive_pos, follow_pos, rand_q(), 17'($urandom()), rand_q(),
              $urandom_range(0, 7) != 0, 1'($urandom_range(0, 1)), no_gap);
  endtask

  task automatic rand_config();
    write_reg(REG_VEL_P, 24'($urandom_range(0, 8192)));
    write_reg(REG_VEL_I, 24'($urandom_range(0, 2048)));
    write_reg(REG_SLIP_P, 24'($urandom_range(0, 8192)));
    write_reg(REG_SLIP_I, 24'($urandom_range(0, 2048)));
    write_reg(REG_ACC_P, 24'($urandom_range(0, 8192)));
    write_reg(REG_ACC_I, 24'($urandom_range(0, 2048)));
    write_reg(REG_VSCALE, 24'($urandom_range(0, 65535) << $urandom_range(0, 8)));
    write_reg(REG_ASCALE,
              24'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 65535)));
  endtask

  initial begin
    rst = 1;
    hold_sink = 0;
    cfg_we = 0; cfg_index = 0; cfg_data = 0;
    s_axis_tvalid = 0; s_axis_tdata = 0; s_axis_tuser = 0;
    drive_pos = 0; follow_pos = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);

    // reset gains: accel p only, so outputs come straight from slew limit
    send_tick(32'd100, 32'd100, 18'sd65536, 17'd1000, 18'sd0, 1'b1, 1'b0, 1'b0);
    send_tick(32'd100, 32'd100, 18'sd0, 17'd0, 18'sd0, 1'b0, 1'b0, 1'b0);
    drain();

    // unity-ish gains, moderate scale
    write_reg(REG_VEL_P, 24'd4096);
    write_reg(REG_VEL_I, 24'd1024);
    write_reg(REG_SLIP_P, 24'd4096);
    write_reg(REG_SLIP_I, 24'd1024);
    write_reg(REG_ACC_P, 24'd4096);
    write_reg(REG_ACC_I, 24'd512);
    write_reg(REG_VSCALE, 24'd4096);
    write_reg(REG_ASCALE, 24'd0);
    // unknown register indexes do not exist (3 bits, 8 regs): all are covered
    send_tick(32'd200, 32'd200, 18'sd65536, 17'd131071, 18'sd0, 1'b1, 1'b1, 1'b0);
    // slip inside the dead band
    send_tick(32'd300, 32'd299, 18'sd0, 17'd500, 18'sd100, 1'b1, 1'b1, 1'b0);
    // slip outside the dead band
    send_tick(32'd400, 32'd300, -18'sd65536, 17'd500, -18'sd65536, 1'b1, 1'b1, 1'b0);
    // slip off with slew limit
    send_tick(32'd500, 32'd400, 18'sd65536, 17'd10, 18'sd65536, 1'b1, 1'b0, 1'b0);
    // full-scale command and present drive
    send_tick(32'd600, 32'd500, 18'h1ffff, 17'd131071, 18'h1ffff, 1'b1, 1'b0, 1'b0);
    send_tick(32'd700, 32'd600, 18'h20000, 17'd131071, 18'h20000, 1'b1, 1'b0, 1'b0);
    // disabled clears integrators
    send_tick(32'd800, 32'd700, 18'sd1234, 17'd0, -18'sd4321, 1'b0, 1'b1, 1'b0);
    // count wraparound
    send_tick(32'h7fffffff, 32'h80000000, 18'sd0, 17'd0, 18'sd0, 1'b1, 1'b1, 1'b0);
    send_tick(32'h80000000, 32'h7fffffff, 18'sd0, 17'd0, 18'sd0, 1'b1, 1'b1, 1'b0);
    send_tick(32'hffffffff, 32'h00000000, 18'sd0, 17'd77, 18'sd0, 1'b1, 1'b0, 1'b0);
    drain();

    // maximum gains and scales
    write_reg(REG_VEL_P, 24'hffff);
    write_reg(REG_VEL_I, 24'hffff);
    write_reg(REG_SLIP_P, 24'hffff);
    write_reg(REG_SLIP_I, 24'hffff);
    write_reg(REG_ACC_P, 24'hffff);
    write_reg(REG_ACC_I, 24'hffff);
    write_reg(REG_VSCALE, 24'hffffff);
    write_reg(REG_ASCALE, 24'hffff);
    drive_pos = 32'hffffffff; follow_pos = 32'h00000000;
    repeat (10) rand_tick(1'b0);
    drain();

    // random phases; receiver hold-off in one, stall-free stretch in another
    for (int ph = 0; ph < 8; ph++) begin
      rand_config();
      if (ph == 2) hold_sink = 1;
      sink_burst = (ph == 5);
      for (int i = 0; i < 48; i++) rand_tick(ph == 2 || ph == 5);
      // sender pause until all results are in
      drain();
    end
    sink_burst = 0;

    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule

### filelist.f
rtl/cptc_pkg.sv
rtl/cptc_datapath.sv
rtl/cptc_ctrl.sv
rtl/cascaded_pi_traction_control_core.sv
tb/tb_cptc_checker.sv
tb/tb_cascaded_pi_traction_control_core.sv
